// File: src/hevb_pkg.sv
package hevb_pkg;

    localparam int EVT_W  = 32;
    localparam int TIME_W = 48;
    localparam int CHAN_W = 4;
    localparam int WORD_W = 16;
    localparam int VAL_W  = 17;
    localparam int SEL_W  = 2;
    localparam int CFG_IDX_W = 4;

    // number of data words a hit carries; data_select saturates to the last one
    localparam int WORDS_PER_HIT = 4;

    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SELECT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE  = 4'd1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic              shift;
        logic              open;
        logic              write;
        logic [CHAN_W-1:0] channel;
        logic [VAL_W-1:0]  word;
        logic [VAL_W-1:0]  init;
    } t_cell_ctl;

endpackage

// File: src/hevb_cell.sv
module hevb_cell
    import hevb_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_next_value,
    output logic [VAL_W-1:0] o_value
);

    logic             w_match;
    logic [VAL_W-1:0] r_value;

    // channel port is narrow; cells past its range never match
    assign w_match = (IDX < (1 << CHAN_W)) && (i_ctl.channel == CHAN_W'(IDX));

    always_ff @(posedge i_clk) begin
        if ((i_ctl.open || i_ctl.write) && w_match) begin
            r_value <= i_ctl.word;
        end else if (i_ctl.open) begin
            r_value <= i_ctl.init;
        end else if (i_ctl.shift) begin
            r_value <= i_next_value;
        end
    end

    assign o_value = r_value;

endmodule

// File: src/hit_to_event_vector_builder_core.sv
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------------------
// hit in   | i_in_valid   | o_in_ready   | i_operation, i_event_number, i_channel,
//          |              |              | i_hit_time, i_word_0 .. i_word_3
// event out| o_out_valid  | i_out_ready  | o_out_event, o_out_time, o_out_channel,
//          |              |              | o_out_value, o_bad_channel_seen, o_last_of_event
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A hit inside the open event leaves input ready. An item that closes an event
// shifts the cell chain out one channel per output handshake, NUM_CHANNELS
// results in all; input is held off during that time, and a closing hit opens
// its event on the last handshake. Output stalls simply freeze the chain.
// Reset (synchronous, active low) leaves no event open; the cells need no reset
// since every event opening loads all of them.
module hit_to_event_vector_builder_core
    import hevb_pkg::*;
#(
    parameter int NUM_CHANNELS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_operation,
    input  logic [EVT_W-1:0]        i_event_number,
    input  logic [CHAN_W-1:0]       i_channel,
    input  logic [TIME_W-1:0]       i_hit_time,
    input  logic [WORD_W-1:0]       i_word_0,
    input  logic [WORD_W-1:0]       i_word_1,
    input  logic [WORD_W-1:0]       i_word_2,
    input  logic [WORD_W-1:0]       i_word_3,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [EVT_W-1:0]        o_out_event,
    output logic [TIME_W-1:0]       o_out_time,
    output logic [CHAN_W-1:0]       o_out_channel,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic                    o_bad_channel_seen,
    output logic                    o_last_of_event,

    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [VAL_W-1:0]        i_cfg_data
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_state             r_state, n_state;
    logic               r_open;
    logic [EVT_W-1:0]   r_evt;
    logic [TIME_W-1:0]  r_time;
    logic               r_bad;
    logic [IDX_W-1:0]   r_idx;
    logic [SEL_W-1:0]   r_data_sel;
    logic [VAL_W-1:0]   r_init;

    // hit that closed the previous event, applied when emission ends
    logic               r_pend;
    logic [EVT_W-1:0]   r_pend_evt;
    logic [TIME_W-1:0]  r_pend_time;
    logic [CHAN_W-1:0]  r_pend_ch;
    logic [VAL_W-1:0]   r_pend_word;

    logic               w_acc_in, w_acc_out, w_is_hit, w_closing, w_last, w_ch_ok;
    logic               w_pend_ch_ok;
    logic [SEL_W-1:0]   w_sel;
    logic [WORD_W-1:0]  w_word;
    logic [IDX_W+3:0]   w_idx_ext;
    t_cell_ctl          w_ctl;
    logic [VAL_W-1:0]   w_cell_val [NUM_CHANNELS+1];

    assign o_cfg_ready = 1'b1;

    assign w_acc_in   = i_in_valid && o_in_ready;
    assign w_acc_out  = o_out_valid && i_out_ready;
    assign w_is_hit   = w_acc_in && (i_operation == OP_HIT);
    assign w_closing  = r_open && (i_event_number != r_evt);
    assign w_last     = (r_idx == IDX_W'(NUM_CHANNELS - 1));
    assign w_ch_ok    = (int'(i_channel) < NUM_CHANNELS);
    assign w_pend_ch_ok = (int'(r_pend_ch) < NUM_CHANNELS);

    assign w_sel = (int'(r_data_sel) >= WORDS_PER_HIT) ? SEL_W'(WORDS_PER_HIT - 1)
                                                       : r_data_sel;
    always_comb begin
        case (w_sel)
            2'd0:    w_word = i_word_0;
            2'd1:    w_word = i_word_1;
            2'd2:    w_word = i_word_2;
            default: w_word = i_word_3;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in && r_open && ((i_operation == OP_FLUSH) || w_closing)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_acc_out && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready  = 1'b1;
            ST_EMIT: o_out_valid = 1'b1;
            default: begin
                o_in_ready  = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctl.shift = w_acc_out;
        w_ctl.open  = (w_is_hit && !r_open) || (w_acc_out && w_last && r_pend);
        w_ctl.write = w_is_hit && r_open && !w_closing;
        w_ctl.init  = r_init;
        if (r_state == ST_IDLE) begin
            w_ctl.channel = i_channel;
            w_ctl.word    = {1'b0, w_word};
        end else begin
            w_ctl.channel = r_pend_ch;
            w_ctl.word    = r_pend_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_open     <= 1'b0;
            r_evt      <= '0;
            r_time     <= '0;
            r_bad      <= 1'b0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_data_sel <= '0;
            r_init     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_DATA_SELECT) begin
                    r_data_sel <= i_cfg_data[SEL_W-1:0];
                end else if (i_cfg_index == CFG_INIT_VALUE) begin
                    r_init <= i_cfg_data;
                end
            end

            if (w_acc_in) begin
                if (i_operation == OP_FLUSH) begin
                    r_pend <= 1'b0;
                end else if (!r_open) begin
                    r_open <= 1'b1;
                    r_evt  <= i_event_number;
                    r_time <= i_hit_time;
                    r_bad  <= !w_ch_ok;
                end else if (w_closing) begin
                    r_pend <= 1'b1;
                end else if (!w_ch_ok) begin
                    r_bad <= 1'b1;
                end
            end

            if (w_acc_out) begin
                if (w_last) begin
                    r_idx <= '0;
                    if (r_pend) begin
                        r_evt  <= r_pend_evt;
                        r_time <= r_pend_time;
                        r_bad  <= !w_pend_ch_ok;
                    end else begin
                        r_open <= 1'b0;
                    end
                    r_pend <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_hit) begin
            r_pend_evt  <= i_event_number;
            r_pend_time <= i_hit_time;
            r_pend_ch   <= i_channel;
            r_pend_word <= {1'b0, w_word};
        end
    end

    assign w_cell_val[NUM_CHANNELS] = r_init;

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
        hevb_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_next_value (w_cell_val[g+1]),
            .o_value      (w_cell_val[g])
        );
    end

    assign w_idx_ext          = {4'b0, r_idx};
    assign o_out_event        = r_evt;
    assign o_out_time         = r_time;
    assign o_out_channel      = w_idx_ext[CHAN_W-1:0];
    assign o_out_value        = w_cell_val[0];
    assign o_bad_channel_seen = r_bad;
    assign o_last_of_event    = w_last;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output sides active together");

    a_emit_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_open)
        else $error("emitting with no open event");

    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_of_event) |=> (!o_out_valid && r_idx == '0))
        else $error("emission did not end after the last element");

    a_pend_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> o_out_valid)
        else $error("pending hit left outside emission");
`endif

endmodule

// File: sim/tb_hit_to_event_vector_builder_core.sv
`timescale 1ns / 1ps

module tb_hit_to_event_vector_builder_core
    import hevb_pkg::*;
();

    localparam int NCH          = 16;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int PRINT_CAP    = 100;

    typedef struct packed {
        logic                           op;
        logic [EVT_W-1:0]               evt;
        logic [CHAN_W-1:0]              chan;
        logic [TIME_W-1:0]              tstamp;
        logic [WORDS_PER_HIT-1:0][WORD_W-1:0] words;
    } t_hit_item;

    typedef struct packed {
        logic [EVT_W-1:0]        evt;
        logic [TIME_W-1:0]       tstamp;
        logic [CHAN_W-1:0]       chan;
        logic signed [VAL_W-1:0] value;
        logic                    bad;
        logic                    last;
    } t_vec_elem;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_operation;
    logic [EVT_W-1:0]        i_event_number;
    logic [CHAN_W-1:0]       i_channel;
    logic [TIME_W-1:0]       i_hit_time;
    logic [WORD_W-1:0]       i_word_0;
    logic [WORD_W-1:0]       i_word_1;
    logic [WORD_W-1:0]       i_word_2;
    logic [WORD_W-1:0]       i_word_3;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [EVT_W-1:0]        o_out_event;
    logic [TIME_W-1:0]       o_out_time;
    logic [CHAN_W-1:0]       o_out_channel;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_bad_channel_seen;
    logic                    o_last_of_event;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [VAL_W-1:0]        i_cfg_data;

    hit_to_event_vector_builder_core #(
        .NUM_CHANNELS(NCH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_event_number     (i_event_number),
        .i_channel          (i_channel),
        .i_hit_time         (i_hit_time),
        .i_word_0           (i_word_0),
        .i_word_1           (i_word_1),
        .i_word_2           (i_word_2),
        .i_word_3           (i_word_3),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_event        (o_out_event),
        .o_out_time         (o_out_time),
        .o_out_channel      (o_out_channel),
        .o_out_value        (o_out_value),
        .o_bad_channel_seen (o_bad_channel_seen),
        .o_last_of_event    (o_last_of_event),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    t_hit_item hit_queue [$];
    t_vec_elem vector_expect [$];
    t_hit_item cur_hit;

    // builder state as the block should hold it
    logic [SEL_W-1:0]        sel_reg;
    logic [VAL_W-1:0]        init_reg;
    logic                    ev_open;
    logic [EVT_W-1:0]        ev_number;
    logic [TIME_W-1:0]       ev_time;
    logic                    ev_bad;
    logic [VAL_W-1:0]        chan_vals [NCH];

    int  mismatches;
    int  cycle_count;
    int  in_gap_left;
    int  out_stall_left;
    bit  in_calm;
    bit  out_calm;
    logic [EVT_W-1:0] last_evt;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic void emit_open_event();
        t_vec_elem e;
        for (int c = 0; c < NCH; c++) begin
            e.evt    = ev_number;
            e.tstamp = ev_time;
            e.chan   = CHAN_W'(c);
            e.value  = chan_vals[c];
            e.bad    = ev_bad;
            e.last   = (c == NCH - 1);
            vector_expect.push_back(e);
        end
        ev_open = 1'b0;
    endfunction

    function automatic void absorb_item(t_hit_item it);
        int sel;
        if (it.op == OP_FLUSH) begin
            if (ev_open)
                emit_open_event();
            return;
        end
        if (ev_open && it.evt != ev_number)
            emit_open_event();
        if (!ev_open) begin
            ev_open   = 1'b1;
            ev_number = it.evt;
            ev_time   = it.tstamp;
            ev_bad    = 1'b0;
            for (int c = 0; c < NCH; c++)
                chan_vals[c] = init_reg;
        end
        sel = int'(sel_reg);
        if (sel >= WORDS_PER_HIT)
            sel = WORDS_PER_HIT - 1;
        if (int'(it.chan) < NCH)
            chan_vals[it.chan] = {1'b0, it.words[sel]};
        else
            ev_bad = 1'b1;
    endfunction

    task automatic check_element();
        t_vec_elem e;
        if (vector_expect.size() == 0) begin
            flag_mismatch($sformatf("unexpected element evt %h ch %0d",
                                    o_out_event, o_out_channel));
            return;
        end
        e = vector_expect.pop_front();
        if (o_out_event !== e.evt)
            flag_mismatch($sformatf("event %h, want %h", o_out_event, e.evt));
        if (o_out_time !== e.tstamp)
            flag_mismatch($sformatf("time %h, want %h", o_out_time, e.tstamp));
        if (o_out_channel !== e.chan)
            flag_mismatch($sformatf("channel %0d, want %0d", o_out_channel, e.chan));
        if (o_out_value !== e.value)
            flag_mismatch($sformatf("ch %0d value %h, want %h", e.chan, o_out_value, e.value));
        if (o_bad_channel_seen !== e.bad)
            flag_mismatch($sformatf("bad channel flag %b, want %b",
                                    o_bad_channel_seen, e.bad));
        if (o_last_of_event !== e.last)
            flag_mismatch($sformatf("ch %0d last %b, want %b", e.chan, o_last_of_event, e.last));
    endtask

    // hit driver
    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            in_gap_left = 0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                absorb_item(cur_hit);
                nxt_valid   = 1'b0;
                in_gap_left = in_calm ? 0 : pick_gap();
            end
            if (!nxt_valid) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                end else if (hit_queue.size() > 0) begin
                    cur_hit = hit_queue.pop_front();
                    i_operation    <= cur_hit.op;
                    i_event_number <= cur_hit.evt;
                    i_channel      <= cur_hit.chan;
                    i_hit_time     <= cur_hit.tstamp;
                    i_word_0       <= cur_hit.words[0];
                    i_word_1       <= cur_hit.words[1];
                    i_word_2       <= cur_hit.words[2];
                    i_word_3       <= cur_hit.words[3];
                    nxt_valid = 1'b1;
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // event vector monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready    <= 1'b0;
            out_stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_element();
            if (out_stall_left > 0) begin
                out_stall_left--;
                i_out_ready <= 1'b0;
            end else if (!out_calm && $urandom_range(0, 99) < 25) begin
                out_stall_left = pick_gap();
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
            @(posedge i_clk) cycle_count++;
        $display("hit_to_event_vector_builder_core verification failed");
        $finish;
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == CFG_DATA_SELECT)
            sel_reg = data[SEL_W-1:0];
        else if (idx == CFG_INIT_VALUE)
            init_reg = data;
        i_cfg_valid <= 1'b0;
    endtask

    // sampled mid-cycle so the driver and monitor updates of the edge are settled
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (hit_queue.size() != 0 || i_in_valid || vector_expect.size() != 0);
        // a hit that closes nothing may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_hit_item rand_hit(logic [EVT_W-1:0] evt, logic [CHAN_W-1:0] ch);
        t_hit_item it;
        it.op     = OP_HIT;
        it.evt    = evt;
        it.chan   = ch;
        it.tstamp = {16'($urandom()), 32'($urandom())};
        for (int w = 0; w < WORDS_PER_HIT; w++)
            it.words[w] = 16'($urandom());
        return it;
    endfunction

    task automatic push_hit(input logic [EVT_W-1:0] evt, input logic [CHAN_W-1:0] ch,
                            input logic [TIME_W-1:0] ts,
                            input logic [WORDS_PER_HIT-1:0][WORD_W-1:0] words);
        t_hit_item it;
        it.op     = OP_HIT;
        it.evt    = evt;
        it.chan   = ch;
        it.tstamp = ts;
        it.words  = words;
        hit_queue.push_back(it);
    endtask

    task automatic push_flush();
        t_hit_item it;
        it    = rand_hit($urandom(), 4'($urandom()));
        it.op = OP_FLUSH;
        hit_queue.push_back(it);
    endtask

    function automatic logic [VAL_W-1:0] pick_init();
        case ($urandom_range(0, 4))
            0: return '1;           // -1
            1: return '0;
            2: return 17'h0FFFF;
            default: return {1'b0, 16'($urandom())};
        endcase
    endfunction

    task automatic gen_random_phase(input int n_items);
        int cnt;
        int r;
        int n_hits;
        logic [EVT_W-1:0] evt;
        cnt = 0;
        while (cnt < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                // noise: lone or doubled flush
                push_flush();
                cnt++;
                if ($urandom_range(0, 1) == 1) begin
                    push_flush();
                    cnt++;
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    evt = last_evt + 1;
                else if (r < 60)
                    evt = $urandom();
                else if (r < 75)
                    evt = last_evt;
                else if (r < 90)
                    evt = last_evt ^ (32'h1 << $urandom_range(0, 31));
                else
                    evt = ($urandom_range(0, 1) == 1) ? '1 : '0;
                n_hits = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24)
                                                     : $urandom_range(1, 5);
                for (int h = 0; h < n_hits; h++)
                    hit_queue.push_back(rand_hit(evt, 4'($urandom())));
                cnt += n_hits;
                last_evt = evt;
                if ($urandom_range(0, 3) == 0) begin
                    push_flush();
                    cnt++;
                end
            end
        end
    endtask

    initial begin
        t_hit_item fl;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = OP_HIT;
        i_event_number = '0;
        i_channel      = '0;
        i_hit_time     = '0;
        i_word_0       = '0;
        i_word_1       = '0;
        i_word_2       = '0;
        i_word_3       = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_DATA_SELECT;
        i_cfg_data     = '0;
        mismatches     = 0;
        in_calm        = 1'b0;
        out_calm       = 1'b0;
        last_evt       = '0;
        sel_reg        = '0;
        init_reg       = '0;
        ev_open        = 1'b0;
        ev_number      = '0;
        ev_time        = '0;
        ev_bad         = 1'b0;
        for (int c = 0; c < NCH; c++)
            chan_vals[c] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, closing by new number and by flush, empty flush
        cfg_write(CFG_DATA_SELECT, {15'($urandom()), 2'd3});
        cfg_write(CFG_INIT_VALUE, '1);
        fl.op     = OP_FLUSH;
        fl.evt    = '1;
        fl.chan   = '1;
        fl.tstamp = '1;
        fl.words  = '1;
        hit_queue.push_back(fl);
        push_hit(32'h0, 4'd0, '0, '0);
        push_hit(32'h0, 4'd15, '1, '1);
        push_hit(32'h0, 4'd15, 48'h1, {16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_hit(32'hFFFF_FFFF, 4'd8, '1, {16'h0008, 16'h0004, 16'h0002, 16'h0001});
        push_flush();
        push_flush();
        push_hit(32'hFFFF_FFFF, 4'd3, 48'h5, {16'h8000, 16'h4000, 16'h2000, 16'h1000});
        wait_drained();

        // select and init change while an event is open
        cfg_write(CFG_DATA_SELECT, 17'd0);
        cfg_write(CFG_INIT_VALUE, 17'h0FFFF);
        push_hit(32'hFFFF_FFFF, 4'd4, 48'h7, {16'h0F0F, 16'hF0F0, 16'h5555, 16'hAAAA});
        push_hit(32'h1, 4'd0, 48'h8000_0000_0000, {16'h1, 16'h2, 16'h3, 16'h7FFF});
        push_hit(32'h1, 4'd1, '0, {16'h4, 16'h5, 16'h6, 16'h7});
        wait_drained();

        cfg_write(CFG_DATA_SELECT, 17'd1);
        cfg_write(CFG_INIT_VALUE, 17'd0);
        cfg_write(4'd9, 17'($urandom()));   // unmapped index, no effect
        push_hit(32'h1, 4'd2, 48'h3, {16'h9, 16'h8, 16'h5555, 16'h7});
        push_hit(32'h8000_0000, 4'd6, 48'h7FFF_FFFF_FFFF, {16'h1, 16'h2, 16'h3, 16'h4});
        wait_drained();

        cfg_write(CFG_DATA_SELECT, 17'd2);
        push_hit(32'h8000_0000, 4'd9, 48'h0, {16'hDEAD, 16'hBEEF, 16'hCAFE, 16'hF00D});
        push_flush();
        wait_drained();

        last_evt = 32'h8000_0000;
        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(CFG_DATA_SELECT, {15'($urandom()), 2'($urandom())});
            cfg_write(CFG_INIT_VALUE, pick_init());
            in_calm  = (ph == 1);
            out_calm = (ph == 1) || (ph == 3 && $urandom_range(0, 1) == 1);
            gen_random_phase(80);
            if (ph == 3)
                push_flush();
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("hit_to_event_vector_builder_core verification clean");
        else
            $display("hit_to_event_vector_builder_core verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/hevb_pkg.sv
src/hevb_cell.sv
src/hit_to_event_vector_builder_core.sv
sim/tb_hit_to_event_vector_builder_core.sv
